// ===== src/sha_pkg.sv =====
// sha-256 hasher shared types, constants and round functions
package sha_pkg;

  localparam int unsigned WORD_W            = 32;
  localparam int unsigned HASH_WORDS        = 8;
  localparam int unsigned SCHED_WORDS       = 16;
  localparam int unsigned ROUNDS            = 64;
  localparam int unsigned ROUND_W           = $clog2(ROUNDS);
  localparam int unsigned BLOCK_BYTES       = 64;
  localparam int unsigned POS_W             = $clog2(BLOCK_BYTES);
  localparam int unsigned BLOCK_BITS        = 512;
  localparam int unsigned LEN_FIELD_MAX     = 64;
  localparam int unsigned LEN_FIELD_DEFAULT = 64;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_upper_mid;
    logic [63:0] digest_lower_mid;
    logic [63:0] digest_low;
  } out_item_t;

  // commands from the sequencer to the compression unit
  typedef struct packed {
    logic                     init;
    logic                     step;
    logic                     fold;
    logic                     hash_rst;
    logic                     byte_we;
    logic [POS_W-1:0]         byte_pos;
    logic [7:0]               byte_val;
    logic                     len_we;
    logic [LEN_FIELD_MAX-1:0] len_val;
  } core_cmd_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] small_sig0(input logic [WORD_W-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sig1(input logic [WORD_W-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/sha_core.sv =====
// sha-256 compression unit: message schedule window, working words, one round per cycle while step is asserted
module sha_core
  import sha_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  core_cmd_t                           cmd,
  output logic                                round_last,
  output logic [HASH_WORDS-1:0][WORD_W-1:0]   hash_words
);

  logic [WORD_W-1:0]  hash_r  [HASH_WORDS];
  logic [WORD_W-1:0]  work_r  [HASH_WORDS];
  logic [WORD_W-1:0]  win_r   [SCHED_WORDS];
  logic [ROUND_W-1:0] round_r;

  logic [WORD_W-1:0] w_cur;
  logic [WORD_W-1:0] w_new;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] ch;
  logic [WORD_W-1:0] maj;
  logic [WORD_W-1:0] byte_word;

  // window slot 0 always holds the schedule word of the current round
  assign w_cur = win_r[0];
  assign w_new = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];

  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + big_sig1(work_r[4]) + ch + ROUND_K[round_r] + w_cur;
  assign t2  = big_sig0(work_r[0]) + maj;

  // big-endian byte lane within the word
  assign byte_word = {{(WORD_W-8){1'b0}}, cmd.byte_val} << {~cmd.byte_pos[1:0], 3'b000};

  assign round_last = (round_r == ROUND_W'(ROUNDS - 1));

  always_comb begin
    for (int i = 0; i < HASH_WORDS; i++) begin
      hash_words[i] = hash_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r <= '0;
    end else if (cmd.init) begin
      round_r <= '0;
    end else if (cmd.step) begin
      round_r <= round_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.hash_rst) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash_r[i] <= INIT_HASH[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash_r[i] <= hash_r[i] + work_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        work_r[i] <= hash_r[i];
      end
    end else if (cmd.step) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fold) begin
      for (int i = 0; i < SCHED_WORDS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.step) begin
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[SCHED_WORDS-1] <= w_new;
    end else begin
      if (cmd.byte_we) begin
        for (int i = 0; i < SCHED_WORDS; i++) begin
          if (cmd.byte_pos[POS_W-1:2] == 4'(i)) begin
            win_r[i] <= win_r[i] | byte_word;
          end
        end
      end
      if (cmd.len_we) begin
        win_r[SCHED_WORDS-2] <= win_r[SCHED_WORDS-2] | cmd.len_val[LEN_FIELD_MAX-1:WORD_W];
        win_r[SCHED_WORDS-1] <= win_r[SCHED_WORDS-1] | cmd.len_val[WORD_W-1:0];
      end
    end
  end

endmodule

// ===== src/sha256_message_hasher.sv =====
// sha-256 message hasher top level: byte packing, padding sequencer and digest register
// one byte word is taken per cycle while a block fills; the byte that completes a block
//   keeps in_ready low through the 64 rounds in the single round unit and the fold
// a final word needs one padding block or two, after one more data block if its byte
//   also completes a block; the digest then sits in the output register until taken
// reset (rst_n low, synchronous) loads the initial hash words and clears the block and count
module sha256_message_hasher
  import sha_pkg::*;
#(
  parameter int unsigned LENGTH_FIELD_BITS = LEN_FIELD_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [POS_W-1:0] PAD_LIMIT =
    POS_W'((BLOCK_BITS - 1 - LENGTH_FIELD_BITS) / 8);
  localparam logic [LENGTH_FIELD_BITS-1:0] BYTE_BITS = LENGTH_FIELD_BITS'(8);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // what the running compression belongs to
  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_PAD  = 2'd1,
    PH_LEN  = 2'd2
  } phase_t;

  state_t                       state_r, state_nxt;
  phase_t                       phase_r, phase_nxt;
  logic                         last_r, last_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [LENGTH_FIELD_BITS-1:0] count_r, count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_data_r, out_data_nxt;

  core_cmd_t                           cmd;
  logic                                round_last;
  logic [HASH_WORDS-1:0][WORD_W-1:0]   hash_words;
  logic                                in_acc;
  logic                                out_free;

  sha_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .round_last (round_last),
    .hash_words (hash_words)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd           = '0;
    cmd.byte_pos  = pos_r;
    cmd.len_val   = LEN_FIELD_MAX'(count_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_data.end_of_message;
          if (in_data.byte_valid) begin
            cmd.byte_we  = 1'b1;
            cmd.byte_val = in_data.data_byte;
            pos_nxt      = pos_r + 1'b1;
            count_nxt    = count_r + BYTE_BITS;
            if (pos_r == POS_W'(BLOCK_BYTES - 1)) begin
              cmd.init  = 1'b1;
              phase_nxt = PH_DATA;
              state_nxt = S_ROUND;
            end else if (in_data.end_of_message) begin
              state_nxt = S_PAD;
            end
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.byte_we  = 1'b1;
        cmd.byte_val = PAD_BYTE;
        if (pos_r > PAD_LIMIT) begin
          // no room for the length: close this block, length goes in a fresh one
          cmd.init  = 1'b1;
          phase_nxt = PH_PAD;
          state_nxt = S_ROUND;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len_we = 1'b1;
        cmd.init   = 1'b1;
        phase_nxt  = PH_LEN;
        state_nxt  = S_ROUND;
      end
      S_ROUND: begin
        cmd.step = 1'b1;
        if (round_last) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        case (phase_r)
          PH_DATA: state_nxt = last_r ? S_PAD : S_IDLE;
          PH_PAD:  state_nxt = S_LEN;
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.digest_high      = {hash_words[0], hash_words[1]};
          out_data_nxt.digest_upper_mid = {hash_words[2], hash_words[3]};
          out_data_nxt.digest_lower_mid = {hash_words[4], hash_words[5]};
          out_data_nxt.digest_low       = {hash_words[6], hash_words[7]};
          cmd.hash_rst                  = 1'b1;
          pos_nxt                       = '0;
          count_nxt                     = '0;
          last_nxt                      = 1'b0;
          state_nxt                     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DATA;
      last_r      <= 1'b0;
      pos_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
